### rtl/mmq_pkg.sv
// Package for the mailbox message queue: sizes, command and status codes,
// and the item type passed from the front end to the back end.
// No dependencies.
package mmq_pkg;

   localparam int NUM_QUEUES      = 10;
   localparam int SLOTS_PER_QUEUE = 16;
   localparam int MESSAGE_BYTES   = 8;

   localparam int CMD_W     = 3;
   localparam int QID_W     = 4;
   localparam int PAYLOAD_W = 64;
   localparam int STATUS_W  = 3;
   localparam int TDATA_W   = 80;

   localparam int QIDX_W  = $clog2(NUM_QUEUES);
   localparam int QCMP_W  = QID_W + 1;
   localparam int PTR_W   = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
   localparam int CNT_W   = $clog2(SLOTS_PER_QUEUE + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int RAM_DEPTH = NUM_QUEUES * SLOTS_PER_QUEUE;
   localparam int ADDR_W  = $clog2(RAM_DEPTH);
   localparam int SLOT_W  = QID_W + PAYLOAD_W;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_IDX_W = 1;
   localparam int FIFO_CNT_W = 2;

   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_HAS_MSG = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INIT    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DEINIT  = 3'd4;

   typedef enum logic [2:0] {
      OP_ENQUEUE,
      OP_DEQUEUE,
      OP_HAS_MSG,
      OP_INIT,
      OP_DEINIT,
      OP_NOP
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_NO_DEST = 3'd1,
      ST_NO_SRC  = 3'd2,
      ST_FULL    = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } back_state_type;

   typedef struct packed {
      op_type                 op;
      logic                   dst_ok;
      logic                   src_ok;
      logic [QID_W-1:0]       queue_id;
      logic [QID_W-1:0]       source_id;
      logic [PAYLOAD_W-1:0]   payload;
   } item_type;

endpackage

### rtl/multi_mailbox_message_queue.sv
// Top level of the mailbox message queue: stream ports, front end and back end.
// Uses mmq_pkg, mmq_front and mmq_back.
//
// Request items on req_ carry a command (enqueue, dequeue, message check,
// queue init, deinit_all), a target queue id, a source id and a payload.
// Every request gives exactly one result item on rsp_, in request order,
// with a status code and, for a successful dequeue, the message.
// The front end decodes and trims each item into a two-entry queue; the back
// end runs the queue bank and holds one result in an output register.
// Each item passes through the front queue and then the result register;
// a successful dequeue also passes through the registered read port of
// the message store on its way.
// Throughput: one item per cycle while rsp_tready is high, but a successful
// dequeue also holds the back end in its read state, as the store has a single read port.
// Reset clears all pointers, counts and enable flags at once; the message
// store is not cleared, since no slot is read before it is written.
// When rsp_tready is low the result is held; the front queue then fills
// and req_tready drops after two more items.
module multi_mailbox_message_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // command[2:0], queue_id[6:3], source_id[10:7], payload[74:11], zero[79:75]
   input  logic [mmq_pkg::TDATA_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // status[2:0], out_source[6:3], out_destination[10:7], out_payload[74:11],
   // zero[79:75]
   output logic [mmq_pkg::TDATA_W-1:0]   rsp_tdata
);

   localparam int FILL_W = mmq_pkg::TDATA_W - mmq_pkg::STATUS_W
                         - 2 * mmq_pkg::QID_W - mmq_pkg::PAYLOAD_W;

   logic                                item_valid, item_ready;
   mmq_pkg::item_type                   item;
   logic [mmq_pkg::STATUS_W-1:0]        rsp_status;
   logic [mmq_pkg::QID_W-1:0]           rsp_source, rsp_destination;
   logic [mmq_pkg::PAYLOAD_W-1:0]       rsp_payload;

   mmq_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_command   (req_tdata[2:0]),
      .req_queue_id  (req_tdata[6:3]),
      .req_source_id (req_tdata[10:7]),
      .req_payload   (req_tdata[74:11]),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item          (item)
   );

   mmq_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item_ready      (item_ready),
      .item            (item),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_source      (rsp_source),
      .rsp_destination (rsp_destination),
      .rsp_payload     (rsp_payload)
   );

   assign rsp_tdata = {{FILL_W{1'b0}}, rsp_payload, rsp_destination, rsp_source, rsp_status};

endmodule

### rtl/mmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mmq_front.sv
// Front end: accepts request items, decodes the command, checks queue ids,
// trims the payload and holds the result in a two-entry queue. Uses mmq_pkg.
module mmq_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [mmq_pkg::CMD_W-1:0]   req_command,
   input  logic [mmq_pkg::QID_W-1:0]   req_queue_id,
   input  logic [mmq_pkg::QID_W-1:0]   req_source_id,
   input  logic [mmq_pkg::PAYLOAD_W-1:0] req_payload,
   output logic                        item_valid,
   input  logic                        item_ready,
   output mmq_pkg::item_type           item
);

   mmq_pkg::item_type               slot_ff [mmq_pkg::FIFO_DEPTH];
   logic [mmq_pkg::FIFO_IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [mmq_pkg::FIFO_IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [mmq_pkg::FIFO_CNT_W-1:0]  count_ff, count_in;
   mmq_pkg::item_type               decoded;
   logic                            push, pop;

   function automatic logic [mmq_pkg::PAYLOAD_W-1:0] trim_payload(
      input logic [mmq_pkg::PAYLOAD_W-1:0] raw
   );
      logic [mmq_pkg::PAYLOAD_W-1:0] res;
      logic                          keep;
      res  = '0;
      keep = 1'b1;
      for (int i = 0; i < mmq_pkg::PAYLOAD_W / 8; i++) begin
         if (i >= mmq_pkg::MESSAGE_BYTES || raw[i*8 +: 8] == 8'd0) begin
            keep = 1'b0;
         end
         if (keep) begin
            res[i*8 +: 8] = raw[i*8 +: 8];
         end
      end
      return res;
   endfunction

   always_comb begin
      case (req_command)
         mmq_pkg::CMD_ENQUEUE: decoded.op = mmq_pkg::OP_ENQUEUE;
         mmq_pkg::CMD_DEQUEUE: decoded.op = mmq_pkg::OP_DEQUEUE;
         mmq_pkg::CMD_HAS_MSG: decoded.op = mmq_pkg::OP_HAS_MSG;
         mmq_pkg::CMD_INIT:    decoded.op = mmq_pkg::OP_INIT;
         mmq_pkg::CMD_DEINIT:  decoded.op = mmq_pkg::OP_DEINIT;
         default:              decoded.op = mmq_pkg::OP_NOP;
      endcase
      decoded.dst_ok    = {1'b0, req_queue_id}  < mmq_pkg::QCMP_W'(mmq_pkg::NUM_QUEUES);
      decoded.src_ok    = {1'b0, req_source_id} < mmq_pkg::QCMP_W'(mmq_pkg::NUM_QUEUES);
      decoded.queue_id  = req_queue_id;
      decoded.source_id = req_source_id;
      decoded.payload   = trim_payload(req_payload);
   end

   assign req_ready  = count_ff != mmq_pkg::FIFO_CNT_W'(mmq_pkg::FIFO_DEPTH);
   assign item_valid = count_ff != '0;
   assign item       = slot_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

### rtl/mmq_back.sv
// Back end: queue pointers, counts and enable flags, the message store and
// the result register. Uses mmq_pkg and mmq_ram.
module mmq_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_valid,
   output logic                           item_ready,
   input  mmq_pkg::item_type              item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mmq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [mmq_pkg::QID_W-1:0]      rsp_source,
   output logic [mmq_pkg::QID_W-1:0]      rsp_destination,
   output logic [mmq_pkg::PAYLOAD_W-1:0]  rsp_payload
);

   mmq_pkg::back_state_type            state_ff, state_in;
   logic [mmq_pkg::PTR_W-1:0]          rp_ff [mmq_pkg::NUM_QUEUES];
   logic [mmq_pkg::PTR_W-1:0]          rp_in [mmq_pkg::NUM_QUEUES];
   logic [mmq_pkg::CNT_W-1:0]          cnt_ff [mmq_pkg::NUM_QUEUES];
   logic [mmq_pkg::CNT_W-1:0]          cnt_in [mmq_pkg::NUM_QUEUES];
   logic [mmq_pkg::NUM_QUEUES-1:0]     en_ff, en_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   mmq_pkg::status_type                status_ff, status_in;
   logic [mmq_pkg::QID_W-1:0]          src_ff, src_in;
   logic [mmq_pkg::QID_W-1:0]          dst_ff, dst_in;
   logic [mmq_pkg::PAYLOAD_W-1:0]      pay_ff, pay_in;
   logic [mmq_pkg::QID_W-1:0]          hold_dst_ff, hold_dst_in;

   logic [mmq_pkg::QIDX_W-1:0]         qi, si;
   logic [mmq_pkg::PTR_W-1:0]          rp;
   logic [mmq_pkg::CNT_W-1:0]          cnt;
   logic                               dst_en, src_en, empty, full;
   logic [mmq_pkg::SUM_W-1:0]          tail_sum;
   logic [mmq_pkg::PTR_W-1:0]          tail_pos;
   logic [mmq_pkg::ADDR_W-1:0]         base_addr;
   logic                               go;
   mmq_pkg::status_type                status_c;

   logic                               wr_en, rd_en;
   logic [mmq_pkg::ADDR_W-1:0]         wr_addr, rd_addr;
   logic [mmq_pkg::SLOT_W-1:0]         wr_data, rd_data;

   mmq_ram #(
      .WIDTH (mmq_pkg::SLOT_W),
      .DEPTH (mmq_pkg::RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign qi        = item.queue_id[mmq_pkg::QIDX_W-1:0];
   assign si        = item.source_id[mmq_pkg::QIDX_W-1:0];
   assign rp        = rp_ff[qi];
   assign cnt       = cnt_ff[qi];
   assign dst_en    = item.dst_ok && en_ff[qi];
   assign src_en    = item.src_ok && en_ff[si];
   assign empty     = !item.dst_ok || cnt == '0;
   assign full      = cnt >= mmq_pkg::CNT_W'(mmq_pkg::SLOTS_PER_QUEUE);
   assign tail_sum  = mmq_pkg::SUM_W'(rp) + mmq_pkg::SUM_W'(cnt);
   assign tail_pos  = (tail_sum >= mmq_pkg::SUM_W'(mmq_pkg::SLOTS_PER_QUEUE))
                    ? mmq_pkg::PTR_W'(tail_sum - mmq_pkg::SUM_W'(mmq_pkg::SLOTS_PER_QUEUE))
                    : mmq_pkg::PTR_W'(tail_sum);
   assign base_addr = mmq_pkg::ADDR_W'(mmq_pkg::ADDR_W'(qi)
                    * mmq_pkg::ADDR_W'(mmq_pkg::SLOTS_PER_QUEUE));
   assign wr_addr   = base_addr + mmq_pkg::ADDR_W'(tail_pos);
   assign rd_addr   = base_addr + mmq_pkg::ADDR_W'(rp);
   assign wr_data   = {item.source_id, item.payload};

   always_comb begin
      status_c = mmq_pkg::ST_OK;
      case (item.op)
         mmq_pkg::OP_ENQUEUE: begin
            if (!dst_en)      status_c = mmq_pkg::ST_NO_DEST;
            else if (!src_en) status_c = mmq_pkg::ST_NO_SRC;
            else if (full)    status_c = mmq_pkg::ST_FULL;
         end
         mmq_pkg::OP_DEQUEUE: begin
            if (empty)        status_c = mmq_pkg::ST_EMPTY;
            else if (!dst_en) status_c = mmq_pkg::ST_NO_DEST;
         end
         mmq_pkg::OP_HAS_MSG: begin
            if (!dst_en)      status_c = mmq_pkg::ST_NO_DEST;
            else if (empty)   status_c = mmq_pkg::ST_EMPTY;
         end
         default: status_c = mmq_pkg::ST_OK;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rp_in        = rp_ff;
      cnt_in       = cnt_ff;
      en_in        = en_ff;
      status_in    = status_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      pay_in       = pay_ff;
      hold_dst_in  = hold_dst_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      go           = 1'b0;
      case (state_ff)
         mmq_pkg::BK_IDLE: begin
            go = item_valid && (!rsp_valid_ff || rsp_ready);
            if (go) begin
               if (item.op == mmq_pkg::OP_DEQUEUE && status_c == mmq_pkg::ST_OK) begin
                  rd_en       = 1'b1;
                  hold_dst_in = item.queue_id;
                  rp_in[qi]   = (rp == mmq_pkg::PTR_W'(mmq_pkg::SLOTS_PER_QUEUE - 1))
                              ? '0 : rp + 1'b1;
                  cnt_in[qi]  = cnt - 1'b1;
                  state_in    = mmq_pkg::BK_READ;
               end else begin
                  rsp_valid_in = 1'b1;
                  status_in    = status_c;
                  src_in       = '0;
                  dst_in       = '0;
                  pay_in       = '0;
                  case (item.op)
                     mmq_pkg::OP_ENQUEUE: begin
                        if (status_c == mmq_pkg::ST_OK) begin
                           wr_en      = 1'b1;
                           cnt_in[qi] = cnt + 1'b1;
                        end
                     end
                     mmq_pkg::OP_INIT: begin
                        if (item.dst_ok) begin
                           rp_in[qi]  = '0;
                           cnt_in[qi] = '0;
                           en_in[qi]  = 1'b1;
                        end
                     end
                     mmq_pkg::OP_DEINIT: en_in = '0;
                     default: ;
                  endcase
               end
            end
         end
         mmq_pkg::BK_READ: begin
            rsp_valid_in = 1'b1;
            status_in    = mmq_pkg::ST_OK;
            src_in       = rd_data[mmq_pkg::SLOT_W-1 -: mmq_pkg::QID_W];
            pay_in       = rd_data[mmq_pkg::PAYLOAD_W-1:0];
            dst_in       = hold_dst_ff;
            state_in     = mmq_pkg::BK_IDLE;
         end
         default: state_in = mmq_pkg::BK_IDLE;
      endcase
   end

   assign item_ready = go;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmq_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         en_ff        <= '0;
         for (int i = 0; i < mmq_pkg::NUM_QUEUES; i++) begin
            rp_ff[i]  <= '0;
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         en_ff        <= en_in;
         rp_ff        <= rp_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      pay_ff      <= pay_in;
      hold_dst_ff <= hold_dst_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_source      = src_ff;
   assign rsp_destination = dst_ff;
   assign rsp_payload     = pay_ff;

   a_read_slot_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == mmq_pkg::BK_READ |-> !rsp_valid_ff)
      else $error("result register busy while store read pending");

   a_read_then_load: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> state_ff == mmq_pkg::BK_READ)
      else $error("store read without read state");

   a_no_wr_rd: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("store written and read by one item");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != mmq_pkg::ST_OK
         |-> src_ff == '0 && dst_ff == '0 && pay_ff == '0)
      else $error("error result carries message fields");

endmodule
